// ----- src/vtp_pkg.sv -----
package vtp_pkg;
	localparam int FRAC_BITS = 14;
	localparam int PSHIFT = FRAC_BITS - 2;
	localparam int NCFG = 7;
	localparam int CFG_AW = 3;
	localparam int QW = 32;

	localparam logic [CFG_AW-1:0] REG_ROT_X = 3'd0;
	localparam logic [CFG_AW-1:0] REG_ROT_Y = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ROT_Z = 3'd2;
	localparam logic [CFG_AW-1:0] REG_TRANS_XY = 3'd3;
	localparam logic [CFG_AW-1:0] REG_TRANS_Z = 3'd4;
	localparam logic [CFG_AW-1:0] REG_DIST = 3'd5;
	localparam logic [CFG_AW-1:0] REG_CENTRE = 3'd6;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [15:0] vertex_z;
		logic last_in;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth_z;
		logic last_out;
	} res_t;

	typedef struct packed {
		logic [CFG_AW-1:0] index;
		logic [63:0] data;
	} cfg_t;

	typedef struct packed {
		logic [62:0] rot_x;
		logic [62:0] rot_y;
		logic [62:0] rot_z;
		logic [63:0] trans_xy;
		logic [31:0] trans_z;
		logic [31:0] persp;
		logic [23:0] centre;
	} regs_t;

	// coefficient idx of a row, after the >>2
	function automatic logic [31:0] coef(input logic [62:0] row, input int idx);
		logic [20:0] f;
		f = row[21*idx +: 21];
		return 32'($signed(f) >>> 2);
	endfunction

	function automatic logic [31:0] term(input logic [15:0] a, input logic [31:0] c);
		logic [31:0] p;
		p = 32'($signed({{16{a[15]}}, a}) * $signed(c));
		return 32'($signed(p) >>> PSHIFT);
	endfunction
endpackage

// ----- src/vtp_if.sv -----
interface vtp_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/vtp_regs.sv -----
module vtp_regs
	import vtp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	vtp_if.sink cfg,
	output regs_t regs
);
	regs_t r_q;
	assign cfg.ready = 1'b1;
	assign regs = r_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q.rot_x <= 63'd16384;
			r_q.rot_y <= 63'd34359738368;
			r_q.rot_z <= 63'd72057594037927936;
			r_q.trans_xy <= '0;
			r_q.trans_z <= '0;
			r_q.persp <= 32'd20840766;
			r_q.centre <= 24'd983360;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_ROT_X: r_q.rot_x <= cfg.data.data[62:0];
				REG_ROT_Y: r_q.rot_y <= cfg.data.data[62:0];
				REG_ROT_Z: r_q.rot_z <= cfg.data.data[62:0];
				REG_TRANS_XY: r_q.trans_xy <= cfg.data.data;
				REG_TRANS_Z: r_q.trans_z <= cfg.data.data[31:0];
				REG_DIST: r_q.persp <= cfg.data.data[31:0];
				REG_CENTRE: r_q.centre <= cfg.data.data[23:0];
				default: ;
			endcase
		end
	end
endmodule

// ----- src/vtp_div.sv -----
// Pipelined signed divider with bypass and output add, one quotient bit per stage, QW+2 stages.
module vtp_div
	import vtp_pkg::*;
(
	input logic clk,
	input logic en,
	input logic [31:0] num,
	input logic [31:0] den,
	input logic [31:0] bypass,
	input logic use_div,
	input logic [31:0] add,
	output logic [31:0] quo
);
	localparam int N = QW;
	logic [N-1:0] rem_s [N+1];
	logic [N-1:0] q_s [N+1];
	logic [N-1:0] d_s [N+1];
	logic neg_s [N+1];
	logic ok_s [N+1];
	logic [31:0] byp_s [N+1];
	logic [31:0] add_s [N+1];
	logic [31:0] out_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			q_s[0] <= num[31] ? 32'(-num) : num;
			d_s[0] <= den[31] ? 32'(-den) : den;
			neg_s[0] <= num[31] ^ den[31];
			ok_s[0] <= use_div && (den != '0);
			byp_s[0] <= use_div ? '0 : bypass;
			add_s[0] <= add;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [N:0] t;
		logic [N-1:0] r;
		always_comb begin
			r = {rem_s[i][N-2:0], q_s[i][N-1]};
			t = {rem_s[i][N-1], r} - {1'b0, d_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!t[N]) begin
					rem_s[i+1] <= t[N-1:0];
				end else begin
					rem_s[i+1] <= r;
				end
				q_s[i+1] <= {q_s[i][N-2:0], ~t[N]};
				d_s[i+1] <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				ok_s[i+1] <= ok_s[i];
				byp_s[i+1] <= byp_s[i];
				add_s[i+1] <= add_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= (ok_s[N] ? (neg_s[N] ? 32'(-q_s[N]) : q_s[N]) : byp_s[N]) + add_s[N];
		end
	end
	assign quo = out_q;
endmodule

// ----- src/vertex_transform_and_project_core.sv -----
// Pipeline from accepted vertex to result: transform, scale, divide and output register
// stages. Throughput: one vertex per cycle; the whole pipe advances while the output
// register is free or being taken.
// Reset: asynchronous; valid bits clear, registers take identity matrix,
// distances 318/318, centre (320, 240).
module vertex_transform_and_project_core
	import vtp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	vtp_if.sink vin,
	vtp_if.source vout,
	vtp_if.sink cfg
);
	localparam int DL = QW + 2;
	localparam int NV = 3 + DL;
	regs_t regs;
	logic en;
	logic [NV-1:0] v_q;
	res_t out_q;
	logic out_v_q;

	vtp_regs u_regs(.clk, .arst_n, .cfg, .regs);

	assign en = !out_v_q || vout.ready;
	assign vin.ready = en;

	logic [31:0] t_s1 [9];
	logic last_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				t_s1[3*r] <= term(vin.data.vertex_x, coef(r == 0 ? regs.rot_x :
					r == 1 ? regs.rot_y : regs.rot_z, 0));
				t_s1[3*r+1] <= term(vin.data.vertex_y, coef(r == 0 ? regs.rot_x :
					r == 1 ? regs.rot_y : regs.rot_z, 1));
				t_s1[3*r+2] <= term(vin.data.vertex_z, coef(r == 0 ? regs.rot_x :
					r == 1 ? regs.rot_y : regs.rot_z, 2));
			end
			last_s1 <= vin.data.last_in;
		end
	end

	logic [31:0] sx_s2, sy_s2, rz_s2;
	logic last_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= regs.trans_xy[31:0] + t_s1[0] + t_s1[1] + t_s1[2];
			sy_s2 <= 32'd0 - regs.trans_xy[63:32] - t_s1[3] - t_s1[4] - t_s1[5];
			rz_s2 <= regs.trans_z + t_s1[6] + t_s1[7] + t_s1[8];
			last_s2 <= last_s1;
		end
	end

	logic [31:0] nx_s3, ny_s3, ex_s3, ey_s3, sx_s3, sy_s3, rz_s3;
	logic neg_s3, last_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3 <= 32'(sx_s2 * {16'd0, regs.persp[15:0]});
			ny_s3 <= 32'(sy_s2 * {16'd0, regs.persp[31:16]});
			ex_s3 <= 32'(-rz_s2) + {16'd0, regs.persp[15:0]};
			ey_s3 <= 32'(-rz_s2) + {16'd0, regs.persp[31:16]};
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			rz_s3 <= rz_s2;
			neg_s3 <= rz_s2[31];
			last_s3 <= last_s2;
		end
	end

	logic [31:0] qx, qy;
	vtp_div u_divx(.clk, .en, .num(nx_s3), .den(ex_s3),
		.bypass(sx_s3), .use_div(neg_s3), .add({20'd0, regs.centre[11:0]}), .quo(qx));
	vtp_div u_divy(.clk, .en, .num(ny_s3), .den(ey_s3),
		.bypass(sy_s3), .use_div(neg_s3), .add({20'd0, regs.centre[23:12]}), .quo(qy));

	logic [31:0] rz_d [DL];
	logic last_d [DL];
	always_ff @(posedge clk) begin
		if (en) begin
			rz_d[0] <= rz_s3;
			last_d[0] <= last_s3;
			for (int i = 1; i < DL; i++) begin
				rz_d[i] <= rz_d[i-1];
				last_d[i] <= last_d[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_q <= {v_q[NV-2:0], vin.valid};
			out_v_q <= v_q[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.screen_x <= qx;
			out_q.screen_y <= qy;
			out_q.depth_z <= rz_d[DL-1];
			out_q.last_out <= last_d[DL-1];
		end
	end

	assign vout.valid = out_v_q;
	assign vout.data = out_q;
endmodule
